FILE: src/acirtx_pkg.sv
// Package for the air-conditioner IR frame transmitter.
// Holds field widths, phase codes, the base frame and the frame builder.
// No dependencies.
package acirtx_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int FRAME_W     = FRAME_BYTES * 8;
    localparam int HALF_BITS   = (FRAME_BYTES / 2) * 8;
    localparam int FIRST_BITS  = HALF_BITS + 3;
    localparam int SECOND_BITS = HALF_BITS + 1;
    localparam int TICK_W      = 10;
    localparam int POS_W       = 7;
    localparam int HALF_IDX_W  = $clog2(HALF_BITS);
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 8;
    localparam int CFG_IDX_W   = 3;

    typedef logic [2:0] t_phase;
    localparam t_phase PH_IDLE   = 3'd0;
    localparam t_phase PH_START  = 3'd1;
    localparam t_phase PH_FIRST  = 3'd2;
    localparam t_phase PH_LINK   = 3'd3;
    localparam t_phase PH_SECOND = 3'd4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_START_MARK  = 3'd0;
    localparam t_cfg_idx REG_START_SPACE = 3'd1;
    localparam t_cfg_idx REG_BIT_MARK    = 3'd2;
    localparam t_cfg_idx REG_ZERO_SPACE  = 3'd3;
    localparam t_cfg_idx REG_ONE_SPACE   = 3'd4;
    localparam t_cfg_idx REG_LINK_MARK   = 3'd5;
    localparam t_cfg_idx REG_LINK_SPACE  = 3'd6;

    localparam logic [FRAME_W-1:0] BASE_FRAME = 64'h8800_2000_5000_000c;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] TEMP_MIN   = 8'd16;
    localparam logic [7:0] TEMP_MAX   = 8'd30;

    function automatic logic [3:0] frame_sum(input logic [FRAME_W-1:0] f);
        logic [7:0] c;
        c = {5'd0, f[2:0]} - 8'd1 + {4'd0, f[11:8]} + 8'd5
            + {3'd0, f[36], 4'd0} + {7'd0, f[24]};
        return c[3:0];
    endfunction

    function automatic logic [FRAME_W-1:0] build_frame(
        input logic       power_on,
        input logic [7:0] temp_tens,
        input logic [7:0] temp_ones,
        input logic [2:0] op_mode,
        input logic [1:0] fan_level
    );
        logic [FRAME_W-1:0] f;
        logic [7:0]         t;
        f = BASE_FRAME;
        if (!power_on) begin
            f[3]     = 1'b0;
            f[63:60] = frame_sum(f);
            f[63:56] = f[63:56] - 8'h80;
        end else begin
            t = (temp_tens - ASCII_ZERO) * 8'd10 + temp_ones - ASCII_ZERO;
            if (t < TEMP_MIN) t = TEMP_MIN;
            if (t > TEMP_MAX) t = TEMP_MAX;
            f[11:8]  = 4'(t - TEMP_MIN);
            f[2:0]   = op_mode;
            f[5:4]   = fan_level;
            f[63:60] = frame_sum(f);
        end
        return f;
    endfunction

endpackage

FILE: src/ac_ir_frame_transmitter_core.sv
// Top level of the air-conditioner IR frame transmitter.
// Uses acirtx_pkg for widths, phase codes and the frame builder.
//
//  Channel   Direction  Handshake                   Payload
//  s_axis    in         s_axis_tvalid/tready        tuser req_type, tdata fields
//  m_axis    out        m_axis_tvalid/tready        tdata gate/busy, tlast, tuser
//  cfg       in         i_cfg_valid/o_cfg_ready     i_cfg_index, i_cfg_data
//
// Each word is processed in the cycle it is accepted; its result word sits in
// the output register in the cycle after. A new word is taken every cycle while
// the output register is empty or being drained. Reset clears the phase,
// counters and output valid and loads the default timing registers. The
// configuration port is always ready.
module ac_ir_frame_transmitter_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] power_on, [8:1] temp_tens, [16:9] temp_ones, [19:17] op_mode,
    // [21:20] fan_level, [23:22] zero
    input  logic [acirtx_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] req_type
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] carrier_gate, [1] busy_res, [7:2] zero
    output logic [acirtx_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                               m_axis_tlast,
    // [0] cmd_rejected
    output logic                               m_axis_tuser,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [acirtx_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [acirtx_pkg::TICK_W-1:0]      i_cfg_data
);

    logic [acirtx_pkg::TICK_W-1:0]  r_start_mark, r_start_space, r_bit_mark;
    logic [acirtx_pkg::TICK_W-1:0]  r_zero_space, r_one_space, r_link_mark, r_link_space;
    logic [acirtx_pkg::FRAME_W-1:0] r_frame, n_frame;
    acirtx_pkg::t_phase             r_phase, n_phase;
    logic [acirtx_pkg::POS_W-1:0]   r_pos, n_pos;
    logic                           r_mark, n_mark;
    logic [acirtx_pkg::TICK_W-1:0]  r_ticks, n_ticks;
    logic                           r_out_valid;
    logic                           r_gate, n_gate, r_busy, n_busy;
    logic                           r_done, n_done, r_rej, n_rej;

    logic                           in_accept;
    logic                           busy;
    logic                           cur_bit;
    logic [acirtx_pkg::TICK_W-1:0]  part_len;
    logic [acirtx_pkg::TICK_W:0]    ticks_inc;
    logic [acirtx_pkg::POS_W-1:0]   pos_inc;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(acirtx_pkg::OUT_DATA_W-2){1'b0}}, r_busy, r_gate};
    assign m_axis_tlast  = r_done;
    assign m_axis_tuser  = r_rej;

    assign busy = (r_phase == acirtx_pkg::PH_START) || (r_phase == acirtx_pkg::PH_FIRST)
               || (r_phase == acirtx_pkg::PH_LINK) || (r_phase == acirtx_pkg::PH_SECOND);

    always_comb begin
        if (r_phase == acirtx_pkg::PH_FIRST) begin
            if (r_pos < acirtx_pkg::POS_W'(acirtx_pkg::HALF_BITS)) begin
                cur_bit = r_frame[{1'b0, r_pos[acirtx_pkg::HALF_IDX_W-1:0]}];
            end else begin
                cur_bit = (r_pos == acirtx_pkg::POS_W'(acirtx_pkg::HALF_BITS + 1));
            end
        end else if (r_pos < acirtx_pkg::POS_W'(acirtx_pkg::HALF_BITS)) begin
            cur_bit = r_frame[{1'b1, r_pos[acirtx_pkg::HALF_IDX_W-1:0]}];
        end else begin
            cur_bit = 1'b0;
        end
    end

    always_comb begin
        if (r_phase == acirtx_pkg::PH_START) begin
            part_len = r_mark ? r_start_mark : r_start_space;
        end else if (r_phase == acirtx_pkg::PH_LINK) begin
            part_len = r_mark ? r_link_mark : r_link_space;
        end else if (r_mark) begin
            part_len = r_bit_mark;
        end else begin
            part_len = cur_bit ? r_one_space : r_zero_space;
        end
    end

    assign ticks_inc = {1'b0, r_ticks} + 1'b1;
    assign pos_inc   = r_pos + 1'b1;

    always_comb begin
        n_frame = r_frame;
        n_phase = r_phase;
        n_pos   = r_pos;
        n_mark  = r_mark;
        n_ticks = r_ticks;
        n_gate  = 1'b0;
        n_busy  = 1'b0;
        n_done  = 1'b0;
        n_rej   = 1'b0;
        if (s_axis_tuser) begin
            n_busy = 1'b1;
            if (busy) begin
                n_rej = 1'b1;
            end else begin
                n_frame = acirtx_pkg::build_frame(s_axis_tdata[0], s_axis_tdata[8:1],
                                                  s_axis_tdata[16:9], s_axis_tdata[19:17],
                                                  s_axis_tdata[21:20]);
                n_phase = acirtx_pkg::PH_START;
                n_pos   = '0;
                n_mark  = 1'b1;
                n_ticks = '0;
            end
        end else if (busy) begin
            n_busy = 1'b1;
            n_gate = r_mark;
            if (ticks_inc >= {1'b0, part_len}) begin
                n_ticks = '0;
                if (r_mark) begin
                    n_mark = 1'b0;
                end else begin
                    n_mark = 1'b1;
                    priority if (r_phase == acirtx_pkg::PH_START) begin
                        n_phase = acirtx_pkg::PH_FIRST;
                        n_pos   = '0;
                    end else if (r_phase == acirtx_pkg::PH_FIRST) begin
                        n_pos = pos_inc;
                        if (pos_inc >= acirtx_pkg::POS_W'(acirtx_pkg::FIRST_BITS)) begin
                            n_phase = acirtx_pkg::PH_LINK;
                            n_pos   = '0;
                        end
                    end else if (r_phase == acirtx_pkg::PH_LINK) begin
                        n_phase = acirtx_pkg::PH_SECOND;
                        n_pos   = '0;
                    end else begin
                        n_pos = pos_inc;
                        if (pos_inc >= acirtx_pkg::POS_W'(acirtx_pkg::SECOND_BITS)) begin
                            n_phase = acirtx_pkg::PH_IDLE;
                            n_pos   = '0;
                            n_mark  = 1'b0;
                            n_done  = 1'b1;
                        end
                    end
                end
            end else begin
                n_ticks = ticks_inc[acirtx_pkg::TICK_W-1:0];
            end
        end else begin
            n_phase = acirtx_pkg::PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_mark  <= 10'd90;
            r_start_space <= 10'd40;
            r_bit_mark    <= 10'd6;
            r_zero_space  <= 10'd6;
            r_one_space   <= 10'd16;
            r_link_mark   <= 10'd7;
            r_link_space  <= 10'd200;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                acirtx_pkg::REG_START_MARK:  r_start_mark  <= i_cfg_data;
                acirtx_pkg::REG_START_SPACE: r_start_space <= i_cfg_data;
                acirtx_pkg::REG_BIT_MARK:    r_bit_mark    <= i_cfg_data;
                acirtx_pkg::REG_ZERO_SPACE:  r_zero_space  <= i_cfg_data;
                acirtx_pkg::REG_ONE_SPACE:   r_one_space   <= i_cfg_data;
                acirtx_pkg::REG_LINK_MARK:   r_link_mark   <= i_cfg_data;
                acirtx_pkg::REG_LINK_SPACE:  r_link_space  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame     <= '0;
            r_phase     <= acirtx_pkg::PH_IDLE;
            r_pos       <= '0;
            r_mark      <= 1'b0;
            r_ticks     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_frame     <= n_frame;
                r_phase     <= n_phase;
                r_pos       <= n_pos;
                r_mark      <= n_mark;
                r_ticks     <= n_ticks;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_gate <= n_gate;
            r_busy <= n_busy;
            r_done <= n_done;
            r_rej  <= n_rej;
        end
    end

endmodule
